// ----- rtl/vccpu_pkg.sv -----
// Shared types, codes and constant tables for the virtual console CPU core.
// Used by vccpu_alu and virtual_console_cpu_core; depends on nothing else.
package vccpu_pkg;

   localparam int unsigned MEM_BYTES  = 4096;
   localparam int unsigned SCREEN_W   = 64;
   localparam int unsigned SCREEN_H   = 32;
   localparam logic [11:0] PC_RESET   = 12'h200;
   localparam logic [11:0] FONT_BASE  = 12'h050;
   localparam logic [11:0] FONT_END   = 12'h0A0;
   localparam logic [15:0] OPC_CLS    = 16'h00E0;
   localparam logic [15:0] OPC_RET    = 16'h00EE;
   localparam logic [7:0]  FN_GET_DT  = 8'h07;
   localparam logic [7:0]  FN_WAITKEY = 8'h0A;
   localparam logic [7:0]  FN_SET_DT  = 8'h15;
   localparam logic [7:0]  FN_SET_ST  = 8'h18;
   localparam logic [7:0]  FN_ADD_I   = 8'h1E;
   localparam logic [7:0]  FN_GLYPH   = 8'h29;
   localparam logic [7:0]  FN_BCD     = 8'h33;
   localparam logic [7:0]  FN_STORE   = 8'h55;
   localparam logic [7:0]  FN_LOAD    = 8'h65;
   localparam logic [7:0]  FN_SKP     = 8'h9E;
   localparam logic [7:0]  FN_SKNP    = 8'hA1;
   localparam logic [3:0]  FLAG_REG   = 4'hF;

   localparam logic [7:0] FONT_ROM [80] = '{
      8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
      8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
      8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
      8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
      8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
      8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
      8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
      8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
   };

   typedef enum logic [2:0] {
      ACT_EXEC  = 3'd0,
      ACT_TICK  = 3'd1,
      ACT_WRMEM = 3'd2,
      ACT_RDROW = 3'd3,
      ACT_RDMEM = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_BAD_OP    = 2'd1,
      STAT_OVERFLOW  = 2'd2,
      STAT_UNDERFLOW = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      GRP_SYS  = 4'h0, GRP_JP   = 4'h1, GRP_CALL = 4'h2, GRP_SEI  = 4'h3,
      GRP_SNEI = 4'h4, GRP_SER  = 4'h5, GRP_LDI  = 4'h6, GRP_ADDI = 4'h7,
      GRP_ALU  = 4'h8, GRP_SNER = 4'h9, GRP_LDIX = 4'hA, GRP_JPV0 = 4'hB,
      GRP_RND  = 4'hC, GRP_DRW  = 4'hD, GRP_KEY  = 4'hE, GRP_MISC = 4'hF
   } op_group_type;

   typedef enum logic [3:0] {
      ALU_MOV  = 4'h0,
      ALU_OR   = 4'h1,
      ALU_AND  = 4'h2,
      ALU_XOR  = 4'h3,
      ALU_ADD  = 4'h4,
      ALU_SUB  = 4'h5,
      ALU_SHR  = 4'h6,
      ALU_SUBN = 4'h7,
      ALU_SHL  = 4'hE
   } alu_op_type;

   typedef struct packed {
      alu_op_type op;
      logic [7:0] a;
      logic [7:0] b;
   } alu_ctrl_type;

   typedef struct packed {
      logic [7:0] value;
      logic       flag;
      logic       legal;
   } alu_res_type;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_FETCH_LO, ST_DECODE, ST_READ_Y,
      ST_GOT_Y, ST_EXEC, ST_WR_VF, ST_CLS, ST_DRAW_RD, ST_DRAW_WR,
      ST_DRAW_END, ST_RET_WAIT, ST_BCD, ST_STORE_RD, ST_STORE_WR,
      ST_LOAD_RD, ST_LOAD_WR, ST_MEM_WAIT, ST_DONE
   } state_type;

endpackage

// ----- rtl/vccpu_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module vccpu_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/vccpu_alu.sv -----
// Shared 8-bit arithmetic and logic unit for register operations.
// Depends on vccpu_pkg for the operation codes and the control structs.
module vccpu_alu
   import vccpu_pkg::*;
(
   input  alu_ctrl_type ctrl,
   output alu_res_type  res
);

   logic [8:0] sum;

   always_comb begin
      sum       = {1'b0, ctrl.a} + {1'b0, ctrl.b};
      res.value = ctrl.b;
      res.flag  = 1'b0;
      res.legal = 1'b1;
      case (ctrl.op)
         ALU_MOV:  res.value = ctrl.b;
         ALU_OR:   res.value = ctrl.a | ctrl.b;
         ALU_AND:  res.value = ctrl.a & ctrl.b;
         ALU_XOR:  res.value = ctrl.a ^ ctrl.b;
         ALU_ADD: begin
            res.value = sum[7:0];
            res.flag  = sum[8];
         end
         ALU_SUB: begin
            res.value = ctrl.a - ctrl.b;
            res.flag  = (ctrl.a >= ctrl.b);
         end
         ALU_SHR: begin
            res.value = {1'b0, ctrl.b[7:1]};
            res.flag  = ctrl.b[0];
         end
         ALU_SUBN: begin
            res.value = ctrl.b - ctrl.a;
            res.flag  = (ctrl.b >= ctrl.a);
         end
         ALU_SHL: begin
            res.value = {ctrl.b[6:0], 1'b0};
            res.flag  = ctrl.b[7];
         end
         default:  res.legal = 1'b0;
      endcase
   end

endmodule

// ----- rtl/virtual_console_cpu_core.sv -----
// Top level of the virtual console CPU core: sequencer, state registers and RAMs.
// Depends on vccpu_pkg, vccpu_ram and vccpu_alu.
//
// Usage: the request channel (req_valid / req_stall) carries one item per
// transfer: execute one instruction, apply a timer tick, write or read a memory
// byte, or read one display row. Every item returns exactly one result on the
// response channel (rsp_valid / rsp_stall). The block takes one item at a time;
// req_stall is high while an item is in progress.
// Each item passes from idle through dispatch to done; a read adds a memory
// wait state. An instruction fetches its two bytes, decodes, reads its register
// operands and executes; those that write VF afterwards or return from a
// subroutine add a VF write or stack read state. A clear-screen then zeroes each
// display row, a sprite draw reads and writes each row and ends by setting VF on
// a collision, BCD writes its three digits, and bulk load and store read and
// write each register. The sequencer walks each RAM one port access per cycle.
// A new request is taken in the cycle after the response is loaded.
// After reset a clearing pass over all 4096 memory addresses writes the font and
// zeroes the memory, display and registers; no request is taken until it completes.
// The program_start register may be written at any time via csr_wr_en.
// When the receiver stalls a pending response, it is held in the output register
// and the block waits with its finished result before returning to idle.
module virtual_console_cpu_core
   import vccpu_pkg::*;
#(
   parameter int unsigned STACK_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_action,
   input  logic [11:0] req_address,
   input  logic [7:0]  req_write_byte,
   input  logic [15:0] req_keys_held,
   input  logic [7:0]  req_random_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_read_data,
   output logic [11:0] rsp_pc_now,
   output logic        rsp_sound_on,
   output logic        rsp_awaiting_key,
   output logic        rsp_screen_changed,
   output logic [1:0]  rsp_status,
   input  logic        csr_wr_en,
   input  logic [11:0] csr_wr_data
);

   localparam int unsigned SI_W = $clog2(STACK_DEPTH);
   localparam int unsigned SP_W = $clog2(STACK_DEPTH + 1);

   state_type   state_ff, state_in;
   action_type  act_ff, act_in;
   logic [11:0] addr_ff, addr_in;
   logic [7:0]  wbyte_ff, wbyte_in;
   logic [15:0] keys_ff, keys_in;
   logic [7:0]  rnd_ff, rnd_in;
   logic [15:0] op_ff, op_in;
   logic [7:0]  vx_ff, vx_in;
   logic [7:0]  vy_ff, vy_in;
   logic [11:0] pc_ff, pc_in;
   logic [15:0] idx_ff, idx_in;
   logic [SP_W-1:0] sp_ff, sp_in;
   logic [7:0]  delay_ff, delay_in;
   logic [7:0]  sound_ff, sound_in;
   logic [4:0]  pend_ff, pend_in;
   logic        blocked_ff, blocked_in;
   logic [11:0] start_ff, start_in;
   logic [11:0] cnt_ff, cnt_in;
   logic        coll_ff, coll_in;
   logic        flag_ff, flag_in;
   logic [63:0] data_ff, data_in;
   logic        changed_ff, changed_in;
   status_type  status_ff, status_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_data_ff, rsp_data_in;
   logic [11:0] rsp_pc_ff, rsp_pc_in;
   logic        rsp_sound_ff, rsp_sound_in;
   logic        rsp_wait_ff, rsp_wait_in;
   logic        rsp_changed_ff, rsp_changed_in;
   status_type  rsp_status_ff, rsp_status_in;

   logic        mem_we;
   logic [11:0] mem_waddr, mem_raddr;
   logic [7:0]  mem_wdata, mem_rdata;
   logic        frm_we;
   logic [4:0]  frm_waddr, frm_raddr;
   logic [63:0] frm_wdata, frm_rdata;
   logic        reg_we;
   logic [3:0]  reg_waddr, reg_raddr;
   logic [7:0]  reg_wdata, reg_rdata;
   logic        stk_we;
   logic [SI_W-1:0] stk_waddr, stk_raddr;
   logic [11:0] stk_wdata, stk_rdata;

   alu_ctrl_type alu_ctrl;
   alu_res_type  alu_res;

   op_group_type grp;
   logic [3:0]  op_x, op_y, op_n;
   logic [7:0]  op_nn;
   logic [11:0] op_nnn;
   logic [SP_W-1:0] sp_dec;
   logic [5:0]  ypos;
   logic [63:0] sprite_mask;
   logic [11:0] mem_ptr;
   logic [16:0] idx_sum;
   logic [7:0]  bcd_hund, bcd_rem, bcd_tens, bcd_ones;
   logic [15:0] bcd_prod;
   logic [4:0]  low_key;
   logic        key_sel;
   logic        row_ok;
   logic        bulk_last;
   logic        can_load;

   vccpu_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
      .clock(clock), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
      .raddr(mem_raddr), .rdata(mem_rdata)
   );

   vccpu_ram #(.WIDTH(SCREEN_W), .DEPTH(SCREEN_H)) u_frame (
      .clock(clock), .we(frm_we), .waddr(frm_waddr), .wdata(frm_wdata),
      .raddr(frm_raddr), .rdata(frm_rdata)
   );

   vccpu_ram #(.WIDTH(8), .DEPTH(16)) u_regs (
      .clock(clock), .we(reg_we), .waddr(reg_waddr), .wdata(reg_wdata),
      .raddr(reg_raddr), .rdata(reg_rdata)
   );

   vccpu_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stack (
      .clock(clock), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
      .raddr(stk_raddr), .rdata(stk_rdata)
   );

   vccpu_alu u_alu (.ctrl(alu_ctrl), .res(alu_res));

   // Instruction fields and helper values.
   always_comb begin
      grp         = op_group_type'(op_ff[15:12]);
      op_x        = op_ff[11:8];
      op_y        = op_ff[7:4];
      op_n        = op_ff[3:0];
      op_nn       = op_ff[7:0];
      op_nnn      = op_ff[11:0];
      sp_dec      = sp_ff - SP_W'(1);
      ypos        = {1'b0, vy_ff[4:0]} + {2'b0, cnt_ff[3:0]};
      row_ok      = (cnt_ff[4:0] < {1'b0, op_n}) && !ypos[5];
      sprite_mask = {mem_rdata, 56'b0} >> vx_ff[5:0];
      mem_ptr     = idx_ff[11:0] + cnt_ff;
      idx_sum     = {1'b0, idx_ff} + {9'b0, vx_ff};
      bulk_last   = (cnt_ff[3:0] == op_x);
      can_load    = !rsp_valid_ff || !rsp_stall;
      key_sel     = keys_ff[vx_ff[3:0]];
      // BCD digits: hundreds by comparison, tens by a reciprocal multiply.
      if (vx_ff >= 8'd200) begin
         bcd_hund = 8'd2;
         bcd_rem  = vx_ff - 8'd200;
      end else if (vx_ff >= 8'd100) begin
         bcd_hund = 8'd1;
         bcd_rem  = vx_ff - 8'd100;
      end else begin
         bcd_hund = 8'd0;
         bcd_rem  = vx_ff;
      end
      bcd_prod = {8'b0, bcd_rem} * 16'd205;
      bcd_tens = {4'b0, bcd_prod[14:11]};
      bcd_ones = bcd_rem - ({bcd_tens[4:0], 3'b0} + {bcd_tens[6:0], 1'b0});
      low_key = 5'd0;
      for (int k = 15; k >= 0; k--) begin
         if (keys_ff[k]) begin
            low_key = 5'(k + 1);
         end
      end
   end

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:    if (cnt_ff == 12'hFFF) state_in = ST_IDLE;
         ST_IDLE:     if (req_valid) state_in = ST_DISPATCH;
         ST_DISPATCH: begin
            unique case (act_ff)
               ACT_EXEC:  state_in = ST_FETCH_LO;
               ACT_RDROW, ACT_RDMEM: state_in = ST_MEM_WAIT;
               default:   state_in = ST_DONE;
            endcase
         end
         ST_FETCH_LO: state_in = ST_DECODE;
         ST_DECODE:   state_in = ST_READ_Y;
         ST_READ_Y:   state_in = ST_GOT_Y;
         ST_GOT_Y:    state_in = ST_EXEC;
         ST_EXEC: begin
            state_in = ST_DONE;
            unique case (grp)
               GRP_SYS: begin
                  if (op_ff == OPC_CLS) begin
                     state_in = ST_CLS;
                  end else if (op_ff == OPC_RET && sp_ff != '0) begin
                     state_in = ST_RET_WAIT;
                  end
               end
               // A plain register move leaves VF alone.
               GRP_ALU:  if (alu_res.legal && op_n != ALU_MOV) state_in = ST_WR_VF;
               GRP_DRW:  state_in = ST_DRAW_RD;
               GRP_MISC: begin
                  case (op_nn)
                     FN_ADD_I: state_in = ST_WR_VF;
                     FN_BCD:   state_in = ST_BCD;
                     FN_STORE: state_in = ST_STORE_RD;
                     FN_LOAD:  state_in = ST_LOAD_RD;
                     default:  state_in = ST_DONE;
                  endcase
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_WR_VF:    state_in = ST_DONE;
         ST_CLS:      if (cnt_ff[4:0] == 5'd31) state_in = ST_DONE;
         ST_DRAW_RD:  state_in = row_ok ? ST_DRAW_WR : ST_DRAW_END;
         ST_DRAW_WR:  state_in = ST_DRAW_RD;
         ST_DRAW_END: state_in = ST_DONE;
         ST_RET_WAIT: state_in = ST_DONE;
         ST_BCD:      if (cnt_ff[1:0] == 2'd2) state_in = ST_DONE;
         ST_STORE_RD: state_in = ST_STORE_WR;
         ST_STORE_WR: state_in = bulk_last ? ST_DONE : ST_STORE_RD;
         ST_LOAD_RD:  state_in = ST_LOAD_WR;
         ST_LOAD_WR:  state_in = bulk_last ? ST_DONE : ST_LOAD_RD;
         ST_MEM_WAIT: state_in = ST_DONE;
         ST_DONE:     if (can_load) state_in = ST_IDLE;
         default:     state_in = ST_CLEAR;
      endcase
   end

   // Datapath and RAM control.
   always_comb begin
      act_in      = act_ff;
      addr_in     = addr_ff;
      wbyte_in    = wbyte_ff;
      keys_in     = keys_ff;
      rnd_in      = rnd_ff;
      op_in       = op_ff;
      vx_in       = vx_ff;
      vy_in       = vy_ff;
      pc_in       = pc_ff;
      idx_in      = idx_ff;
      sp_in       = sp_ff;
      delay_in    = delay_ff;
      sound_in    = sound_ff;
      pend_in     = pend_ff;
      blocked_in  = blocked_ff;
      start_in    = csr_wr_en ? csr_wr_data : start_ff;
      cnt_in      = cnt_ff;
      coll_in     = coll_ff;
      flag_in     = flag_ff;
      data_in     = data_ff;
      changed_in  = changed_ff;
      status_in   = status_ff;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      rsp_data_in    = rsp_data_ff;
      rsp_pc_in      = rsp_pc_ff;
      rsp_sound_in   = rsp_sound_ff;
      rsp_wait_in    = rsp_wait_ff;
      rsp_changed_in = rsp_changed_ff;
      rsp_status_in  = rsp_status_ff;
      req_stall   = (state_ff != ST_IDLE);
      mem_we      = 1'b0;
      mem_waddr   = mem_ptr;
      mem_wdata   = 8'd0;
      mem_raddr   = mem_ptr;
      frm_we      = 1'b0;
      frm_waddr   = ypos[4:0];
      frm_wdata   = frm_rdata ^ sprite_mask;
      frm_raddr   = ypos[4:0];
      reg_we      = 1'b0;
      reg_waddr   = op_x;
      reg_wdata   = alu_res.value;
      reg_raddr   = op_y;
      stk_we      = 1'b0;
      stk_waddr   = sp_ff[SI_W-1:0];
      stk_wdata   = pc_ff;
      stk_raddr   = sp_dec[SI_W-1:0];
      alu_ctrl.op = (grp == GRP_ADDI) ? ALU_ADD : alu_op_type'(op_n);
      alu_ctrl.a  = vx_ff;
      alu_ctrl.b  = (grp == GRP_ADDI) ? op_nn : vy_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff;
            if (cnt_ff >= FONT_BASE && cnt_ff < FONT_END) begin
               mem_wdata = FONT_ROM[7'(cnt_ff - FONT_BASE)];
            end
            frm_we    = 1'b1;
            frm_waddr = cnt_ff[4:0];
            frm_wdata = '0;
            reg_we    = 1'b1;
            reg_waddr = cnt_ff[3:0];
            reg_wdata = 8'd0;
            cnt_in    = cnt_ff + 12'd1;
         end
         ST_IDLE: begin
            if (req_valid) begin
               act_in   = action_type'(req_action);
               addr_in  = req_address;
               wbyte_in = req_write_byte;
               keys_in  = req_keys_held;
               rnd_in   = req_random_byte;
            end
         end
         ST_DISPATCH: begin
            data_in    = '0;
            changed_in = 1'b0;
            status_in  = STAT_OK;
            mem_raddr  = addr_ff;
            frm_raddr  = addr_ff[4:0];
            unique case (act_ff)
               ACT_EXEC: mem_raddr = pc_ff;
               ACT_TICK: begin
                  if (delay_ff != 8'd0) delay_in = delay_ff - 8'd1;
                  if (sound_ff != 8'd0) sound_in = sound_ff - 8'd1;
               end
               ACT_WRMEM: begin
                  mem_we    = 1'b1;
                  mem_waddr = addr_ff;
                  mem_wdata = wbyte_ff;
               end
               default: ;
            endcase
         end
         ST_FETCH_LO: begin
            op_in[15:8] = mem_rdata;
            mem_raddr   = pc_ff + 12'd1;
         end
         ST_DECODE: begin
            op_in[7:0] = mem_rdata;
            reg_raddr  = (grp == GRP_JPV0) ? 4'd0 : op_x;
            pc_in      = pc_ff + 12'd2;
            blocked_in = 1'b0;
         end
         ST_READ_Y: begin
            vx_in     = reg_rdata;
            reg_raddr = op_y;
         end
         ST_GOT_Y: vy_in = reg_rdata;
         ST_EXEC: begin
            cnt_in = '0;
            unique case (grp)
               GRP_SYS: begin
                  if (op_ff == OPC_CLS) begin
                     changed_in = 1'b1;
                  end else if (op_ff == OPC_RET) begin
                     if (sp_ff != '0) begin
                        sp_in = sp_dec;
                     end else begin
                        pc_in     = start_ff;
                        status_in = STAT_UNDERFLOW;
                     end
                  end else begin
                     status_in = STAT_BAD_OP;
                  end
               end
               GRP_JP:   pc_in = op_nnn;
               GRP_CALL: begin
                  if (sp_ff >= SP_W'(STACK_DEPTH)) begin
                     status_in = STAT_OVERFLOW;
                  end else begin
                     stk_we = 1'b1;
                     sp_in  = sp_ff + SP_W'(1);
                     pc_in  = op_nnn;
                  end
               end
               GRP_SEI:  if (vx_ff == op_nn) pc_in = pc_ff + 12'd2;
               GRP_SNEI: if (vx_ff != op_nn) pc_in = pc_ff + 12'd2;
               GRP_SER:  if (vx_ff == vy_ff) pc_in = pc_ff + 12'd2;
               GRP_SNER: if (vx_ff != vy_ff) pc_in = pc_ff + 12'd2;
               GRP_LDI: begin
                  reg_we    = 1'b1;
                  reg_wdata = op_nn;
               end
               GRP_ADDI: reg_we = 1'b1;
               GRP_ALU: begin
                  if (alu_res.legal) begin
                     reg_we  = 1'b1;
                     flag_in = alu_res.flag;
                  end else begin
                     status_in = STAT_BAD_OP;
                  end
               end
               GRP_LDIX: idx_in = {4'b0, op_nnn};
               GRP_JPV0: pc_in = op_nnn + {4'b0, vx_ff};
               GRP_RND: begin
                  reg_we    = 1'b1;
                  reg_wdata = rnd_ff & op_nn;
               end
               GRP_DRW: begin
                  reg_we     = 1'b1;
                  reg_waddr  = FLAG_REG;
                  reg_wdata  = 8'd0;
                  coll_in    = 1'b0;
                  changed_in = 1'b1;
               end
               GRP_KEY: begin
                  if (op_nn == FN_SKP) begin
                     if (key_sel) pc_in = pc_ff + 12'd2;
                  end else if (op_nn == FN_SKNP) begin
                     if (!key_sel) pc_in = pc_ff + 12'd2;
                  end else begin
                     status_in = STAT_BAD_OP;
                  end
               end
               GRP_MISC: begin
                  case (op_nn)
                     FN_GET_DT: begin
                        reg_we    = 1'b1;
                        reg_wdata = delay_ff;
                     end
                     FN_WAITKEY: begin
                        if (pend_ff != 5'd0 && !keys_ff[4'(pend_ff - 5'd1)]) begin
                           reg_we    = 1'b1;
                           reg_wdata = {4'b0, 4'(pend_ff - 5'd1)};
                           pend_in   = 5'd0;
                        end else begin
                           if (pend_ff == 5'd0) pend_in = low_key;
                           pc_in      = pc_ff - 12'd2;
                           blocked_in = 1'b1;
                        end
                     end
                     FN_SET_DT: delay_in = vx_ff;
                     FN_SET_ST: sound_in = vx_ff;
                     FN_ADD_I: begin
                        idx_in  = idx_sum[15:0];
                        flag_in = (idx_sum[16:12] != 5'd0);
                     end
                     FN_GLYPH: idx_in = {4'b0, FONT_BASE}
                                        + {10'b0, vx_ff[3:0], 2'b0} + {12'b0, vx_ff[3:0]};
                     FN_BCD, FN_STORE, FN_LOAD: ;
                     default: status_in = STAT_BAD_OP;
                  endcase
               end
               default: ;
            endcase
         end
         ST_WR_VF: begin
            reg_we    = 1'b1;
            reg_waddr = FLAG_REG;
            reg_wdata = {7'b0, flag_ff};
         end
         ST_CLS: begin
            frm_we    = 1'b1;
            frm_waddr = cnt_ff[4:0];
            frm_wdata = '0;
            cnt_in    = cnt_ff + 12'd1;
         end
         ST_DRAW_RD: ;
         ST_DRAW_WR: begin
            frm_we  = 1'b1;
            coll_in = coll_ff | ((frm_rdata & sprite_mask) != '0);
            cnt_in  = cnt_ff + 12'd1;
         end
         ST_DRAW_END: begin
            if (coll_ff) begin
               reg_we    = 1'b1;
               reg_waddr = FLAG_REG;
               reg_wdata = 8'd1;
            end
         end
         ST_RET_WAIT: pc_in = stk_rdata;
         ST_BCD: begin
            mem_we = 1'b1;
            case (cnt_ff[1:0])
               2'd0:    mem_wdata = bcd_hund;
               2'd1:    mem_wdata = bcd_tens;
               default: mem_wdata = bcd_ones;
            endcase
            cnt_in = cnt_ff + 12'd1;
         end
         ST_STORE_RD: reg_raddr = cnt_ff[3:0];
         ST_STORE_WR: begin
            mem_we    = 1'b1;
            mem_wdata = reg_rdata;
            cnt_in    = cnt_ff + 12'd1;
            if (bulk_last) idx_in = idx_ff + {12'b0, op_x} + 16'd1;
         end
         ST_LOAD_RD: ;
         ST_LOAD_WR: begin
            reg_we    = 1'b1;
            reg_waddr = cnt_ff[3:0];
            reg_wdata = mem_rdata;
            cnt_in    = cnt_ff + 12'd1;
            if (bulk_last) idx_in = idx_ff + {12'b0, op_x} + 16'd1;
         end
         ST_MEM_WAIT: begin
            data_in = (act_ff == ACT_RDROW) ? frm_rdata : {56'b0, mem_rdata};
         end
         ST_DONE: begin
            if (can_load) begin
               rsp_valid_in   = 1'b1;
               rsp_data_in    = data_ff;
               rsp_pc_in      = pc_ff;
               rsp_sound_in   = (sound_ff != 8'd0);
               rsp_wait_in    = blocked_ff;
               rsp_changed_in = changed_ff;
               rsp_status_in  = status_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
         pc_ff        <= PC_RESET;
         idx_ff       <= '0;
         sp_ff        <= '0;
         delay_ff     <= '0;
         sound_ff     <= '0;
         pend_ff      <= '0;
         blocked_ff   <= 1'b0;
         start_ff     <= PC_RESET;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pc_ff        <= pc_in;
         idx_ff       <= idx_in;
         sp_ff        <= sp_in;
         delay_ff     <= delay_in;
         sound_ff     <= sound_in;
         pend_ff      <= pend_in;
         blocked_ff   <= blocked_in;
         start_ff     <= start_in;
         cnt_ff       <= cnt_in;
      end
      act_ff         <= act_in;
      addr_ff        <= addr_in;
      wbyte_ff       <= wbyte_in;
      keys_ff        <= keys_in;
      rnd_ff         <= rnd_in;
      op_ff          <= op_in;
      vx_ff          <= vx_in;
      vy_ff          <= vy_in;
      coll_ff        <= coll_in;
      flag_ff        <= flag_in;
      data_ff        <= data_in;
      changed_ff     <= changed_in;
      status_ff      <= status_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_pc_ff      <= rsp_pc_in;
      rsp_sound_ff   <= rsp_sound_in;
      rsp_wait_ff    <= rsp_wait_in;
      rsp_changed_ff <= rsp_changed_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_data      = rsp_data_ff;
   assign rsp_pc_now         = rsp_pc_ff;
   assign rsp_sound_on       = rsp_sound_ff;
   assign rsp_awaiting_key   = rsp_wait_ff;
   assign rsp_screen_changed = rsp_changed_ff;
   assign rsp_status         = rsp_status_ff;

endmodule
